### hw/rtl/hnd_pkg.sv
// hnd_pkg: shared types, sizes, codes and a helper function for the
// Hamming nearest-descriptor match block. Depends on nothing.
`default_nettype none

package hnd_pkg;

    // Table and descriptor sizing
    localparam int MAX_OLD_ENTRIES = 1024;
    localparam int DESC_BITS       = 256;
    localparam int DESC_WORDS      = DESC_BITS / 64;
    localparam int NUM_BYTES       = DESC_BITS / 8;
    localparam int ENTRY_W         = $clog2(MAX_OLD_ENTRIES);
    localparam int CNT_W           = $clog2(MAX_OLD_ENTRIES + 1);
    localparam int WORD_W          = (DESC_WORDS > 1) ? $clog2(DESC_WORDS) : 1;
    localparam int DIST_W          = $clog2(DESC_BITS + 1);
    localparam int CFG_W           = 9;
    localparam int CMP_W           = (DIST_W > CFG_W) ? DIST_W : CFG_W;
    localparam int BYTE_CNT_W      = 4;
    localparam int WORD_CNT_W      = 7;

    // Register reset values
    localparam logic [CFG_W-1:0] ACCEPT_THRESHOLD_RST = 9'd80;
    localparam logic [CFG_W-1:0] SEARCH_CEILING_RST   = 9'd128;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEPT_THRESHOLD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_CEILING   = 1'd1;

    // Item actions
    localparam logic [1:0] ACT_LOAD_DESC   = 2'd0;
    localparam logic [1:0] ACT_LOAD_POINTS = 2'd1;
    localparam logic [1:0] ACT_QUERY       = 2'd2;

    // Input item beat
    typedef struct packed {
        logic [1:0]         action;
        logic [9:0]         entry_index;
        logic [1:0]         word_select;
        logic [63:0]        descriptor_word;
        logic signed [15:0] pixel_x;
        logic signed [15:0] pixel_y;
        logic signed [15:0] norm_x;
        logic signed [15:0] norm_y;
        logic [10:0]        search_count;
    } item_t;

    // Result beat
    typedef struct packed {
        logic               match_found;
        logic [9:0]         best_index;
        logic [8:0]         best_distance;
        logic signed [15:0] match_pixel_x;
        logic signed [15:0] match_pixel_y;
        logic signed [15:0] match_norm_x;
        logic signed [15:0] match_norm_y;
    } result_t;

    // Tag that travels with each entry through the distance pipeline
    typedef struct packed {
        logic               valid;
        logic [ENTRY_W-1:0] idx;
    } tag_t;

    // Bit count of one byte
    function automatic logic [BYTE_CNT_W-1:0] popcount8(input logic [7:0] v);
        logic [BYTE_CNT_W-1:0] acc;
        acc = '0;
        for (int b = 0; b < 8; b++) begin
            acc = acc + BYTE_CNT_W'(v[b]);
        end
        return acc;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/hnd_desc_mem.sv
// hnd_desc_mem: stored descriptor table, one bank per 64-bit word so a
// whole descriptor is read per cycle. Depends on hnd_pkg.
`default_nettype none

module hnd_desc_mem (
    input  wire logic                                  clk,
    input  wire logic                                  wr_en,
    input  wire logic [hnd_pkg::WORD_W-1:0]            wr_word,
    input  wire logic [hnd_pkg::ENTRY_W-1:0]           wr_addr,
    input  wire logic [63:0]                           wr_data,
    input  wire logic [hnd_pkg::ENTRY_W-1:0]           rd_addr,
    output logic [hnd_pkg::DESC_WORDS-1:0][63:0]       rd_data
);

    // One bank per descriptor word, registered read
    for (genvar g = 0; g < hnd_pkg::DESC_WORDS; g++) begin : g_bank
        logic [63:0] bank [hnd_pkg::MAX_OLD_ENTRIES];
        logic [63:0] rd_q;

        always_ff @(posedge clk)
        begin
            if (wr_en && (wr_word == hnd_pkg::WORD_W'(g)))
            begin
                bank[wr_addr] <= wr_data;
            end
            rd_q <= bank[rd_addr];
        end

        assign rd_data[g] = rd_q;
    end

endmodule

`default_nettype wire

### hw/rtl/hnd_point_mem.sv
// hnd_point_mem: per-entry point table (pixel and normalized points packed
// into 64 bits), one write and one registered read port. Depends on hnd_pkg.
`default_nettype none

module hnd_point_mem (
    input  wire logic                         clk,
    input  wire logic                         wr_en,
    input  wire logic [hnd_pkg::ENTRY_W-1:0]  wr_addr,
    input  wire logic [63:0]                  wr_data,
    input  wire logic [hnd_pkg::ENTRY_W-1:0]  rd_addr,
    output logic [63:0]                       rd_data
);

    logic [63:0] mem [hnd_pkg::MAX_OLD_ENTRIES];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

### hw/rtl/hnd_dist_unit.sv
// hnd_dist_unit: shared three-stage Hamming distance pipeline; byte counts,
// word sums, descriptor total. Depends on hnd_pkg.
`default_nettype none

module hnd_dist_unit (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [hnd_pkg::DESC_BITS-1:0] query,
    input  wire logic [hnd_pkg::DESC_BITS-1:0] stored,
    input  wire hnd_pkg::tag_t                 tag_in,
    output logic [hnd_pkg::DIST_W-1:0]         ham_dist,
    output hnd_pkg::tag_t                      tag_out,
    output logic                               pipe_busy
);

    logic [hnd_pkg::BYTE_CNT_W-1:0] byte_cnt_next [hnd_pkg::NUM_BYTES];
    logic [hnd_pkg::BYTE_CNT_W-1:0] byte_cnt_reg  [hnd_pkg::NUM_BYTES];
    logic [hnd_pkg::WORD_CNT_W-1:0] word_cnt_next [hnd_pkg::DESC_WORDS];
    logic [hnd_pkg::WORD_CNT_W-1:0] word_cnt_reg  [hnd_pkg::DESC_WORDS];
    logic [hnd_pkg::DIST_W-1:0]     dist_next;
    logic [hnd_pkg::DIST_W-1:0]     dist_reg;
    logic [hnd_pkg::DESC_BITS-1:0]  diff;
    hnd_pkg::tag_t                  tag1_reg;
    hnd_pkg::tag_t                  tag2_reg;
    hnd_pkg::tag_t                  tag3_reg;

    // Stage 1: XOR and per-byte bit counts
    assign diff = query ^ stored;

    always_comb
    begin
        for (int i = 0; i < hnd_pkg::NUM_BYTES; i++) begin
            byte_cnt_next[i] = hnd_pkg::popcount8(diff[i*8 +: 8]);
        end
    end

    // Stage 2: eight byte counts per 64-bit word
    always_comb
    begin
        for (int w = 0; w < hnd_pkg::DESC_WORDS; w++) begin
            word_cnt_next[w] = '0;
            for (int b = 0; b < 8; b++) begin
                word_cnt_next[w] = word_cnt_next[w]
                    + hnd_pkg::WORD_CNT_W'(byte_cnt_reg[w*8 + b]);
            end
        end
    end

    // Stage 3: total over the descriptor words
    always_comb
    begin
        dist_next = '0;
        for (int w = 0; w < hnd_pkg::DESC_WORDS; w++) begin
            dist_next = dist_next + hnd_pkg::DIST_W'(word_cnt_reg[w]);
        end
    end

    // Data stages
    always_ff @(posedge clk)
    begin
        byte_cnt_reg <= byte_cnt_next;
        word_cnt_reg <= word_cnt_next;
        dist_reg     <= dist_next;
    end

    // Tag stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag1_reg <= '0;
            tag2_reg <= '0;
            tag3_reg <= '0;
        end
        else
        begin
            tag1_reg <= tag_in;
            tag2_reg <= tag1_reg;
            tag3_reg <= tag2_reg;
        end
    end

    assign ham_dist  = dist_reg;
    assign tag_out   = tag3_reg;
    assign pipe_busy = tag1_reg.valid || tag2_reg.valid || tag3_reg.valid;

endmodule

`default_nettype wire

### hw/rtl/hamming_nearest_descriptor_match.sv
// hamming_nearest_descriptor_match: top level; command decode, scan
// sequencer, running minimum and result. Depends on hnd_pkg, hnd_desc_mem,
// hnd_point_mem and hnd_dist_unit.
//
// Use:
//   An item beat is taken at a clock edge with start high and busy low.
//   Load beats (descriptor word or entry points) write the tables;
//   busy stays low. Query beats for the leading words only store the
//   word. The query beat carrying the last word starts a scan over
//   entries 0 .. search_count-1 (capped at the table size).
//   The scan reads one stored descriptor per cycle and pushes it through
//   a shared distance pipeline of three stages after the table read.
//   result_valid is high for exactly one cycle with the result beat,
//   after the scan has drained the pipeline and the point table is read;
//   busy is high from the accepting edge until the result cycle ends, so
//   no new item is taken before then.
//   The receiver cannot stall: a result is shown once and is gone.
//   Configuration beats (cfg_valid, cfg_ready always high) write the
//   accept threshold and search ceiling; they are meant for idle time.
//   Reset sets the threshold to 80, the ceiling to 128 and the held
//   query words to zero; table contents are undefined until loaded.
`default_nettype none

module hamming_nearest_descriptor_match (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire hnd_pkg::item_t                    item,
    output logic                                   result_valid,
    output hnd_pkg::result_t                       result,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [hnd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [hnd_pkg::CFG_W-1:0]         cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_POINT  = 4'b0100,
        S_RESULT = 4'b1000
    } state_t;

    state_t                           state_reg, state_next;
    logic [hnd_pkg::CNT_W-1:0]        issue_cnt_reg, issue_cnt_next;
    logic [hnd_pkg::CNT_W-1:0]        count_reg, count_next;
    logic [hnd_pkg::CFG_W-1:0]        best_reg, best_next;
    logic [hnd_pkg::ENTRY_W-1:0]      best_idx_reg, best_idx_next;
    logic                             found_reg, found_next;
    logic [hnd_pkg::CFG_W-1:0]        thr_reg;
    logic [hnd_pkg::CFG_W-1:0]        ceil_reg;
    logic [63:0]                      query_reg [hnd_pkg::DESC_WORDS];
    hnd_pkg::tag_t                    tag_mem_reg;

    logic                             accept;
    logic                             entry_ok;
    logic                             word_ok;
    logic                             word_last;
    logic [hnd_pkg::WORD_W-1:0]       word_sel;
    logic [hnd_pkg::ENTRY_W-1:0]      entry_addr;
    logic                             desc_wr;
    logic                             point_wr;
    logic                             query_wr;
    logic                             scan_go;
    logic [hnd_pkg::CNT_W-1:0]        count_sat;
    logic                             issue_en;
    hnd_pkg::tag_t                    issue_tag;
    logic [hnd_pkg::DESC_WORDS-1:0][63:0] desc_rd;
    logic [hnd_pkg::DESC_BITS-1:0]    query_flat;
    logic [hnd_pkg::DESC_BITS-1:0]    stored_flat;
    logic [63:0]                      point_rd;
    logic [63:0]                      point_wdata;
    logic [hnd_pkg::DIST_W-1:0]       ham_dist;
    hnd_pkg::tag_t                    dist_tag;
    logic                             dist_busy;
    logic                             better;
    logic                             match;

    // Item decode
    assign accept     = start && !busy;
    assign entry_ok   = 32'(item.entry_index) < hnd_pkg::MAX_OLD_ENTRIES;
    assign word_ok    = 32'(item.word_select) < hnd_pkg::DESC_WORDS;
    assign word_last  = 32'(item.word_select) == (hnd_pkg::DESC_WORDS - 1);
    assign word_sel   = hnd_pkg::WORD_W'(item.word_select);
    assign entry_addr = hnd_pkg::ENTRY_W'(item.entry_index);

    always_comb
    begin
        desc_wr  = 1'b0;
        point_wr = 1'b0;
        query_wr = 1'b0;
        scan_go  = 1'b0;
        case (item.action)
            hnd_pkg::ACT_LOAD_DESC:
            begin
                desc_wr = accept && entry_ok && word_ok;
            end
            hnd_pkg::ACT_LOAD_POINTS:
            begin
                point_wr = accept && entry_ok;
            end
            hnd_pkg::ACT_QUERY:
            begin
                query_wr = accept && word_ok;
                scan_go  = accept && word_last;
            end
            default:
            begin
                desc_wr = 1'b0;
            end
        endcase
    end

    assign count_sat = (32'(item.search_count) > hnd_pkg::MAX_OLD_ENTRIES)
                     ? hnd_pkg::CNT_W'(hnd_pkg::MAX_OLD_ENTRIES)
                     : hnd_pkg::CNT_W'(item.search_count);

    assign point_wdata = {item.norm_y, item.norm_x, item.pixel_y, item.pixel_x};

    // Scan issue
    assign issue_en        = (state_reg == S_SCAN) && (issue_cnt_reg < count_reg);
    assign issue_tag.valid = issue_en;
    assign issue_tag.idx   = issue_cnt_reg[hnd_pkg::ENTRY_W-1:0];

    // Tables
    hnd_desc_mem u_desc_mem (
        .clk     (clk),
        .wr_en   (desc_wr),
        .wr_word (word_sel),
        .wr_addr (entry_addr),
        .wr_data (item.descriptor_word),
        .rd_addr (issue_tag.idx),
        .rd_data (desc_rd)
    );

    hnd_point_mem u_point_mem (
        .clk     (clk),
        .wr_en   (point_wr),
        .wr_addr (entry_addr),
        .wr_data (point_wdata),
        .rd_addr (best_idx_reg),
        .rd_data (point_rd)
    );

    // Distance pipeline
    always_comb
    begin
        for (int w = 0; w < hnd_pkg::DESC_WORDS; w++) begin
            query_flat[w*64 +: 64] = query_reg[w];
        end
    end

    assign stored_flat = desc_rd;

    hnd_dist_unit u_dist (
        .clk       (clk),
        .rst_n     (rst_n),
        .query     (query_flat),
        .stored    (stored_flat),
        .tag_in    (tag_mem_reg),
        .ham_dist  (ham_dist),
        .tag_out   (dist_tag),
        .pipe_busy (dist_busy)
    );

    // Sequencer and running minimum
    assign better = dist_tag.valid
                 && (hnd_pkg::CMP_W'(ham_dist) < hnd_pkg::CMP_W'(best_reg));

    always_comb
    begin
        state_next     = state_reg;
        issue_cnt_next = issue_cnt_reg;
        count_next     = count_reg;
        best_next      = best_reg;
        best_idx_next  = best_idx_reg;
        found_next     = found_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (scan_go)
                begin
                    state_next     = S_SCAN;
                    issue_cnt_next = '0;
                    count_next     = count_sat;
                    best_next      = ceil_reg;
                    best_idx_next  = '0;
                    found_next     = 1'b0;
                end
            end
            S_SCAN:
            begin
                if (issue_en)
                begin
                    issue_cnt_next = issue_cnt_reg + hnd_pkg::CNT_W'(1);
                end
                if (better)
                begin
                    best_next     = hnd_pkg::CFG_W'(ham_dist);
                    best_idx_next = dist_tag.idx;
                    found_next    = 1'b1;
                end
                if (!issue_en && !tag_mem_reg.valid && !dist_busy)
                begin
                    state_next = S_POINT;
                end
            end
            S_POINT:
            begin
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            issue_cnt_reg <= '0;
            count_reg     <= '0;
            best_reg      <= hnd_pkg::SEARCH_CEILING_RST;
            best_idx_reg  <= '0;
            found_reg     <= 1'b0;
            tag_mem_reg   <= '0;
            for (int w = 0; w < hnd_pkg::DESC_WORDS; w++) begin
                query_reg[w] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            issue_cnt_reg <= issue_cnt_next;
            count_reg     <= count_next;
            best_reg      <= best_next;
            best_idx_reg  <= best_idx_next;
            found_reg     <= found_next;
            tag_mem_reg   <= issue_tag;
            if (query_wr)
            begin
                query_reg[word_sel] <= item.descriptor_word;
            end
        end
    end

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg  <= hnd_pkg::ACCEPT_THRESHOLD_RST;
            ceil_reg <= hnd_pkg::SEARCH_CEILING_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                hnd_pkg::CFG_ACCEPT_THRESHOLD: thr_reg  <= cfg_data;
                hnd_pkg::CFG_SEARCH_CEILING:   ceil_reg <= cfg_data;
                default:                       thr_reg  <= thr_reg;
            endcase
        end
    end

    // Result beat
    assign match        = found_reg && (best_reg < thr_reg);
    assign busy         = (state_reg != S_IDLE);
    assign result_valid = (state_reg == S_RESULT);

    assign result.match_found   = match;
    assign result.best_index    = 10'(best_idx_reg);
    assign result.best_distance = best_reg;
    assign result.match_pixel_x = match ? point_rd[15:0]  : 16'sd0;
    assign result.match_pixel_y = match ? point_rd[31:16] : 16'sd0;
    assign result.match_norm_x  = match ? point_rd[47:32] : 16'sd0;
    assign result.match_norm_y  = match ? point_rd[63:48] : 16'sd0;

    // Checks
    a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result strobe longer than one cycle");

    a_scan_starts: assert property (@(posedge clk) disable iff (!rst_n)
        scan_go |=> (state_reg == S_SCAN))
        else $error("last query word did not start a scan");

    a_dist_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        dist_tag.valid |-> (state_reg == S_SCAN))
        else $error("distance beat outside scan");

    a_issue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (issue_cnt_reg <= count_reg))
        else $error("scan issued past entry count");

    a_best_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> (best_reg <= ceil_reg))
        else $error("best distance above search ceiling");

endmodule

`default_nettype wire
